// ===== design/cso_pkg.sv =====
// shared types and constants for the clock slew and offset block
package cso_pkg;

  // seconds width of the raw clock and of the slew offset
  localparam int SEC_BITS      = 40;
  // real-time offset seconds width, two guard bits above the raw clock
  localparam int WIDE_SEC_BITS = SEC_BITS + 2;
  localparam int NSEC_W        = 30;
  // remaining correction seconds, at most 2146
  localparam int REM_SEC_W     = 12;

  localparam int IN_TDATA_W    = 168;
  localparam int IN_TUSER_W    = 4;
  localparam int OUT_TDATA_W   = 112;

  localparam logic [NSEC_W-1:0] NS_PER_SEC  = 30'd1000000000;
  localparam logic [NSEC_W-1:0] NSEC_MAX    = 30'd999999999;
  localparam logic [NSEC_W-1:0] STEP_RESET  = 30'd5000;
  localparam logic [9:0]        NS_PER_US   = 10'd1000;
  localparam logic [19:0]       US_PER_SEC  = 20'd1000000;
  localparam logic signed [20:0] ADJ_USEC_LIMIT = 21'sd1000000;
  localparam logic signed [12:0] ADJ_SEC_LIMIT  = 13'sd2145;
  // floor(x / 1000) = (x * RECIP_1000) >> RECIP_SHIFT for x below 2^30
  localparam logic [30:0] RECIP_1000  = 31'd1099511628;
  localparam int          RECIP_SHIFT = 40;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADJUST = 2'd1,
    OP_SET    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SEL_RAW  = 2'd0,
    SEL_MONO = 2'd1,
    SEL_REAL = 2'd2,
    SEL_BAD  = 2'd3
  } sel_t;

  typedef enum logic {
    ST_OK  = 1'b0,
    ST_BAD = 1'b1
  } status_t;

  typedef struct packed {
    op_t                   op;
    logic [SEC_BITS-1:0]   hw_sec;
    logic [NSEC_W-1:0]     hw_nsec;
    logic signed [12:0]    adj_sec;
    logic signed [20:0]    adj_usec;
    logic [SEC_BITS-1:0]   set_sec;
    logic [19:0]           set_usec;
    sel_t                  clock_sel;
  } item_t;

  typedef struct packed {
    status_t                        status;
    logic signed [WIDE_SEC_BITS-1:0] out_sec;
    logic [NSEC_W-1:0]              out_nsec;
    logic signed [12:0]             old_sec;
    logic signed [20:0]             old_usec;
  } result_t;

endpackage

// ===== design/clock_slew_and_offset.sv =====
// top level of the clock slew and offset corrector
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   tdata: hw/adj/set fields, tuser: op, clock_sel
//   out_     master     out_tvalid/out_tready tdata: time and old correction, tuser: status
//   cfg_     write      cfg_we                cfg_wdata: slew step in nanoseconds
//
// one transaction per cycle while out_tready allows; an accepted transaction goes
// through the input register, then the update logic into the result register
// the slew and offset registers update as an item moves into the result register,
// the step register on a configuration write
// a stalled result holds the result register and then the input register
// reset (rst_n low, synchronous) clears all offsets and sets the step to 5000 ns
module clock_slew_and_offset (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cso_pkg::NSEC_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // hw_sec, hw_nsec, adj_sec, adj_usec, set_sec, set_usec, zero pad
  input  logic [cso_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op, clock_sel
  input  logic [cso_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_sec, out_nsec, old_sec, old_usec, zero pad
  output logic [cso_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic                            out_tuser
);

  logic             advance;
  logic             item_valid;
  cso_pkg::item_t   item;
  cso_pkg::result_t result;

  cso_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  cso_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (item_valid && advance),
    .item      (item),
    .result    (result)
  );

  cso_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== design/cso_in_stage.sv =====
// input register stage: unpacks and holds one transaction
module cso_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cso_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [cso_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            advance,
  output logic                            item_valid,
  output cso_pkg::item_t                  item
);

  logic           valid_r;
  cso_pkg::item_t item_r;
  cso_pkg::item_t item_nxt;

  // stage frees up when empty or when its item moves on
  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  // field unpack
  always_comb begin
    item_nxt.op        = cso_pkg::op_t'(in_tuser[1:0]);
    item_nxt.clock_sel = cso_pkg::sel_t'(in_tuser[3:2]);
    item_nxt.hw_sec    = in_tdata[39:0];
    item_nxt.hw_nsec   = in_tdata[69:40];
    item_nxt.adj_sec   = $signed(in_tdata[82:70]);
    item_nxt.adj_usec  = $signed(in_tdata[103:83]);
    item_nxt.set_sec   = in_tdata[143:104];
    item_nxt.set_usec  = in_tdata[163:144];
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== design/cso_core.sv =====
// clock state registers, slew update and result computation
module cso_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [cso_pkg::NSEC_W-1:0]   cfg_wdata,
  input  logic                         fire,
  input  cso_pkg::item_t               item,
  output cso_pkg::result_t             result
);

  typedef struct packed {
    logic                        c;
    logic [cso_pkg::NSEC_W-1:0]  ns;
  } nsc_t;

  // nanosecond add with carry out, both operands below one second
  function automatic nsc_t ns_add(input logic [cso_pkg::NSEC_W-1:0] a,
                                  input logic [cso_pkg::NSEC_W-1:0] b);
    logic [cso_pkg::NSEC_W:0] s;
    nsc_t r;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, cso_pkg::NS_PER_SEC}) begin
      r.c  = 1'b1;
      r.ns = cso_pkg::NSEC_W'(s - {1'b0, cso_pkg::NS_PER_SEC});
    end else begin
      r.c  = 1'b0;
      r.ns = s[cso_pkg::NSEC_W-1:0];
    end
    return r;
  endfunction

  // nanosecond subtract with borrow out
  function automatic nsc_t ns_sub(input logic [cso_pkg::NSEC_W-1:0] a,
                                  input logic [cso_pkg::NSEC_W-1:0] b);
    nsc_t r;
    if (a < b) begin
      r.c  = 1'b1;
      r.ns = a + cso_pkg::NS_PER_SEC - b;
    end else begin
      r.c  = 1'b0;
      r.ns = a - b;
    end
    return r;
  endfunction

  // pacing step and pending correction
  logic [cso_pkg::NSEC_W-1:0]        step_r;
  logic [cso_pkg::REM_SEC_W-1:0]     rem_sec_r, rem_sec_nxt;
  logic [cso_pkg::NSEC_W-1:0]        rem_nsec_r, rem_nsec_nxt;
  logic                              up_r, up_nxt;
  // slew offset and combined slew plus step offset
  logic [cso_pkg::SEC_BITS-1:0]      adj_sec_r, adj_sec_nxt;
  logic [cso_pkg::NSEC_W-1:0]        adj_nsec_r, adj_nsec_nxt;
  logic [cso_pkg::WIDE_SEC_BITS-1:0] real_sec_r, real_sec_nxt;
  logic [cso_pkg::NSEC_W-1:0]        real_nsec_r, real_nsec_nxt;

  logic [cso_pkg::NSEC_W-1:0] hw_ns;
  logic [cso_pkg::NSEC_W-1:0] step_c;
  logic [cso_pkg::NSEC_W-1:0] tick_d;
  nsc_t                       rem_t, adj_t, real_t, set_t, mono_s, real_s;
  logic [60:0]                ou_prod;
  logic [19:0]                ou;
  logic                       adj_zero, adj_bad, set_bad;
  logic signed [13:0]         s0, s1, s2;
  logic signed [21:0]         u0, u1, u2;
  logic [13:0]                mag_s;
  logic [21:0]                mag_u;
  logic [cso_pkg::NSEC_W-1:0] load_ns;
  logic                       load_up;
  logic [cso_pkg::NSEC_W-1:0] set_tns;
  logic [cso_pkg::WIDE_SEC_BITS-1:0] hw_sec_w, mono_sec, realt_sec, set_sec_w;

  assign hw_ns  = (item.hw_nsec > cso_pkg::NSEC_MAX) ? cso_pkg::NSEC_MAX : item.hw_nsec;
  assign step_c = (step_r > cso_pkg::NSEC_MAX) ? cso_pkg::NSEC_MAX : step_r;
  assign hw_sec_w  = {2'b00, item.hw_sec};
  assign set_sec_w = {2'b00, item.set_sec};

  // tick: one step, cut to what remains
  always_comb begin
    if ((rem_sec_r == '0) && (rem_nsec_r < step_c)) begin
      tick_d = rem_nsec_r;
    end else begin
      tick_d = step_c;
    end
    rem_t = ns_sub(rem_nsec_r, tick_d);
    if (up_r) begin
      adj_t  = ns_add(adj_nsec_r, tick_d);
      real_t = ns_add(real_nsec_r, tick_d);
    end else begin
      adj_t  = ns_sub(adj_nsec_r, tick_d);
      real_t = ns_sub(real_nsec_r, tick_d);
    end
  end

  // pending correction reported in microseconds
  assign ou_prod = {31'b0, rem_nsec_r} * {30'b0, cso_pkg::RECIP_1000};
  assign ou      = ou_prod[cso_pkg::RECIP_SHIFT+19:cso_pkg::RECIP_SHIFT];

  // adjust request: validate and normalize to sign plus magnitude
  always_comb begin
    adj_zero = (item.adj_sec == '0) && (item.adj_usec == '0);
    adj_bad  = (item.adj_usec > cso_pkg::ADJ_USEC_LIMIT) ||
               (item.adj_usec < -cso_pkg::ADJ_USEC_LIMIT) ||
               (item.adj_sec > cso_pkg::ADJ_SEC_LIMIT) ||
               (item.adj_sec < -cso_pkg::ADJ_SEC_LIMIT);
    s0 = 14'(item.adj_sec);
    u0 = 22'(item.adj_usec);
    s1 = s0;
    u1 = u0;
    // a full second of microseconds moves into the seconds
    if (u0 == $signed({2'b00, cso_pkg::US_PER_SEC})) begin
      s1 = s0 + 14'sd1;
      u1 = '0;
    end else if (u0 == -$signed({2'b00, cso_pkg::US_PER_SEC})) begin
      s1 = s0 - 14'sd1;
      u1 = '0;
    end
    s2 = s1;
    u2 = u1;
    // bring both parts to the same sign
    if ((s1 > 14'sd0) && (u1 < 22'sd0)) begin
      s2 = s1 - 14'sd1;
      u2 = u1 + $signed({2'b00, cso_pkg::US_PER_SEC});
    end else if ((s1 < 14'sd0) && (u1 > 22'sd0)) begin
      s2 = s1 + 14'sd1;
      u2 = u1 - $signed({2'b00, cso_pkg::US_PER_SEC});
    end
    load_up = (s2 > 14'sd0) || (u2 > 22'sd0);
    mag_s   = (s2 < 14'sd0) ? 14'(-s2) : 14'(s2);
    mag_u   = (u2 < 22'sd0) ? 22'(-u2) : 22'(u2);
    load_ns = {10'b0, mag_u[19:0]} * {20'b0, cso_pkg::NS_PER_US};
  end

  // set time: real offset becomes new time minus raw time
  always_comb begin
    set_bad = item.set_usec >= cso_pkg::US_PER_SEC;
    set_tns = {10'b0, item.set_usec} * {20'b0, cso_pkg::NS_PER_US};
    set_t   = ns_sub(set_tns, hw_ns);
  end

  // clock reads
  always_comb begin
    mono_s    = ns_add(hw_ns, adj_nsec_r);
    real_s    = ns_add(hw_ns, real_nsec_r);
    mono_sec  = hw_sec_w + {{2{adj_sec_r[cso_pkg::SEC_BITS-1]}}, adj_sec_r} +
                cso_pkg::WIDE_SEC_BITS'(mono_s.c);
    realt_sec = hw_sec_w + real_sec_r + cso_pkg::WIDE_SEC_BITS'(real_s.c);
  end

  // next state and result
  always_comb begin
    rem_sec_nxt   = rem_sec_r;
    rem_nsec_nxt  = rem_nsec_r;
    up_nxt        = up_r;
    adj_sec_nxt   = adj_sec_r;
    adj_nsec_nxt  = adj_nsec_r;
    real_sec_nxt  = real_sec_r;
    real_nsec_nxt = real_nsec_r;
    result        = '0;
    case (item.op)
      cso_pkg::OP_TICK: begin
        rem_sec_nxt   = rem_sec_r - cso_pkg::REM_SEC_W'(rem_t.c);
        rem_nsec_nxt  = rem_t.ns;
        adj_nsec_nxt  = adj_t.ns;
        real_nsec_nxt = real_t.ns;
        if (up_r) begin
          adj_sec_nxt  = adj_sec_r + cso_pkg::SEC_BITS'(adj_t.c);
          real_sec_nxt = real_sec_r + cso_pkg::WIDE_SEC_BITS'(real_t.c);
        end else begin
          adj_sec_nxt  = adj_sec_r - cso_pkg::SEC_BITS'(adj_t.c);
          real_sec_nxt = real_sec_r - cso_pkg::WIDE_SEC_BITS'(real_t.c);
        end
      end
      cso_pkg::OP_ADJUST: begin
        result.old_sec  = up_r ? $signed({1'b0, rem_sec_r}) : -$signed({1'b0, rem_sec_r});
        result.old_usec = up_r ? $signed({1'b0, ou}) : -$signed({1'b0, ou});
        if (adj_bad) begin
          result.status = cso_pkg::ST_BAD;
        end else if (!adj_zero) begin
          up_nxt       = load_up;
          rem_sec_nxt  = mag_s[cso_pkg::REM_SEC_W-1:0];
          rem_nsec_nxt = load_ns;
        end
      end
      cso_pkg::OP_SET: begin
        if (set_bad) begin
          result.status = cso_pkg::ST_BAD;
        end else begin
          rem_sec_nxt   = '0;
          rem_nsec_nxt  = '0;
          real_nsec_nxt = set_t.ns;
          real_sec_nxt  = set_sec_w - hw_sec_w - cso_pkg::WIDE_SEC_BITS'(set_t.c);
        end
      end
      cso_pkg::OP_READ: begin
        case (item.clock_sel)
          cso_pkg::SEL_RAW: begin
            result.out_sec  = $signed(hw_sec_w);
            result.out_nsec = hw_ns;
          end
          cso_pkg::SEL_MONO: begin
            result.out_sec  = $signed(mono_sec);
            result.out_nsec = mono_s.ns;
          end
          cso_pkg::SEL_REAL: begin
            result.out_sec  = $signed(realt_sec);
            result.out_nsec = real_s.ns;
          end
          default: begin
            result.status = cso_pkg::ST_BAD;
          end
        endcase
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // pacing step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cso_pkg::STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  // clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_sec_r   <= '0;
      rem_nsec_r  <= '0;
      up_r        <= 1'b0;
      adj_sec_r   <= '0;
      adj_nsec_r  <= '0;
      real_sec_r  <= '0;
      real_nsec_r <= '0;
    end else if (fire) begin
      rem_sec_r   <= rem_sec_nxt;
      rem_nsec_r  <= rem_nsec_nxt;
      up_r        <= up_nxt;
      adj_sec_r   <= adj_sec_nxt;
      adj_nsec_r  <= adj_nsec_nxt;
      real_sec_r  <= real_sec_nxt;
      real_nsec_r <= real_nsec_nxt;
    end
  end

endmodule

// ===== design/cso_out_stage.sv =====
// result register stage: holds one result transaction and packs it
module cso_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_valid,
  input  cso_pkg::result_t                result,
  output logic                            advance,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cso_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);

  logic             valid_r;
  cso_pkg::result_t res_r;

  // result register takes a new value when empty or being drained
  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;

  // field pack
  assign out_tuser = res_r.status;
  assign out_tdata = {6'b0, res_r.old_usec, res_r.old_sec, res_r.out_nsec, res_r.out_sec};

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= result;
    end
  end

endmodule

// ===== design/cso_checker.sv =====
// port-level checks for the clock slew and offset corrector
module cso_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cso_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a failed transaction reads back zero time
  a_bad_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[71:0] == 72'd0)
    else $error("time returned with invalid status");

  // nanoseconds stay normalized
  a_nsec_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:42] < cso_pkg::NS_PER_SEC)
    else $error("nanoseconds out of range");

endmodule

bind clock_slew_and_offset cso_checker u_cso_checker (.*);

// ===== bench/clock_slew_and_offset_checker.sv =====
// checker that predicts and compares every result of the clock slew and offset block
module clock_slew_and_offset_checker
  import cso_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [NSEC_W-1:0]      cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     mismatches,
  output int                     awaiting
);

  localparam int IN_FIELDS_W  = 164;
  localparam int OUT_FIELDS_W = 106;
  localparam int REM_NS_W     = 42;

  typedef struct packed {
    logic [WIDE_SEC_BITS-1:0] sec;
    logic [NSEC_W-1:0]        nsec;
  } stamp_t;

  // corrector state as the block should hold it
  logic [NSEC_W-1:0]        step_ns;
  logic [REM_NS_W-1:0]      slew_left_ns;
  logic                     slew_fast;
  logic [SEC_BITS-1:0]      slew_sec;
  logic [NSEC_W-1:0]        slew_nsec;
  logic [WIDE_SEC_BITS-1:0] offset_sec;
  logic [NSEC_W-1:0]        offset_nsec;

  result_t results_due[$];
  int      errors;

  // time sum, both nanosecond parts below one second
  function automatic stamp_t stamp_add(stamp_t a, stamp_t b);
    stamp_t      s;
    logic [31:0] n;
    n = {2'b0, a.nsec} + {2'b0, b.nsec};
    s.sec = a.sec + b.sec;
    if (n >= {2'b0, NS_PER_SEC}) begin
      s.sec = s.sec + 1'b1;
      n = n - {2'b0, NS_PER_SEC};
    end
    s.nsec = n[NSEC_W-1:0];
    return s;
  endfunction

  // time difference with a borrow out of the seconds
  function automatic stamp_t stamp_sub(stamp_t a, stamp_t b);
    stamp_t      s;
    logic [31:0] n;
    s.sec = a.sec - b.sec;
    if (a.nsec < b.nsec) begin
      s.sec = s.sec - 1'b1;
      n = {2'b0, a.nsec} + {2'b0, NS_PER_SEC} - {2'b0, b.nsec};
    end else begin
      n = {2'b0, a.nsec - b.nsec};
    end
    s.nsec = n[NSEC_W-1:0];
    return s;
  endfunction

  // expected result of one request, updating the predicted state
  function automatic result_t predict_clock_result(item_t it);
    result_t             r;
    stamp_t              raw, slew, offset, d, t, target;
    logic [REM_NS_W-1:0] amount, whole, frac;
    logic [NSEC_W-1:0]   hw_ns;
    longint              a_sec, a_usec, total;
    r = '0;
    hw_ns = (it.hw_nsec > NSEC_MAX) ? NSEC_MAX : it.hw_nsec;
    raw.sec = {2'b0, it.hw_sec};
    raw.nsec = hw_ns;
    slew.sec = {{(WIDE_SEC_BITS-SEC_BITS){slew_sec[SEC_BITS-1]}}, slew_sec};
    slew.nsec = slew_nsec;
    offset.sec = offset_sec;
    offset.nsec = offset_nsec;
    case (it.op)
      OP_TICK: begin
        // one pacing step toward the pending correction, clipped to what is left
        if (slew_left_ns != 0) begin
          amount = {12'b0, ((step_ns > NSEC_MAX) ? NSEC_MAX : step_ns)};
          if (amount > slew_left_ns) begin
            amount = slew_left_ns;
          end
          d.sec = '0;
          d.nsec = amount[NSEC_W-1:0];
          t = slew_fast ? stamp_add(slew, d) : stamp_sub(slew, d);
          slew_sec = t.sec[SEC_BITS-1:0];
          slew_nsec = t.nsec;
          slew_left_ns = slew_left_ns - amount;
        end
      end
      OP_ADJUST: begin
        // pending correction is reported whatever happens next
        whole = slew_left_ns / {12'b0, NS_PER_SEC};
        frac = (slew_left_ns % {12'b0, NS_PER_SEC}) / {32'b0, NS_PER_US};
        if (!slew_fast) begin
          whole = -whole;
          frac = -frac;
        end
        r.old_sec = whole[12:0];
        r.old_usec = frac[20:0];
        a_sec = $signed(it.adj_sec);
        a_usec = $signed(it.adj_usec);
        if (a_sec == 0 && a_usec == 0) begin
          // query only
        end else if (a_usec > ADJ_USEC_LIMIT || a_usec < -ADJ_USEC_LIMIT ||
                     a_sec > ADJ_SEC_LIMIT || a_sec < -ADJ_SEC_LIMIT) begin
          r.status = ST_BAD;
        end else begin
          total = a_sec * 64'sd1000000000 + a_usec * 64'sd1000;
          if (total > 0) begin
            slew_fast = 1'b1;
            slew_left_ns = total[REM_NS_W-1:0];
          end else begin
            slew_fast = 1'b0;
            total = -total;
            slew_left_ns = total[REM_NS_W-1:0];
          end
        end
      end
      OP_SET: begin
        if (it.set_usec >= US_PER_SEC) begin
          r.status = ST_BAD;
        end else begin
          // step offset absorbs the gap between requested and current real time
          slew_left_ns = '0;
          t = stamp_add(stamp_add(raw, slew), offset);
          target.sec = {2'b0, it.set_sec};
          target.nsec = {10'b0, it.set_usec} * {20'b0, NS_PER_US};
          t = stamp_add(offset, stamp_sub(target, t));
          offset_sec = t.sec;
          offset_nsec = t.nsec;
        end
      end
      default: begin
        if (it.clock_sel == SEL_BAD) begin
          r.status = ST_BAD;
        end else begin
          t = raw;
          if (it.clock_sel != SEL_RAW) begin
            t = stamp_add(t, slew);
          end
          if (it.clock_sel == SEL_REAL) begin
            t = stamp_add(t, offset);
          end
          r.out_sec = t.sec;
          r.out_nsec = t.nsec;
        end
      end
    endcase
    return r;
  endfunction

  // track config, predict on accepted requests, compare on accepted results
  always @(posedge clk) begin : watch
    item_t   req;
    result_t wanted, seen;
    if (!rst_n) begin
      step_ns = STEP_RESET;
      slew_left_ns = '0;
      slew_fast = 1'b0;
      slew_sec = '0;
      slew_nsec = '0;
      offset_sec = '0;
      offset_nsec = '0;
      results_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        step_ns = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        {req.set_usec, req.set_sec, req.adj_usec, req.adj_sec, req.hw_nsec,
         req.hw_sec} = in_tdata[IN_FIELDS_W-1:0];
        req.op = op_t'(in_tuser[1:0]);
        req.clock_sel = sel_t'(in_tuser[3:2]);
        results_due.push_back(predict_clock_result(req));
      end
      if (out_tvalid && out_tready) begin
        {seen.old_usec, seen.old_sec, seen.out_nsec, seen.out_sec} =
          out_tdata[OUT_FIELDS_W-1:0];
        seen.status = status_t'(out_tuser);
        if (results_due.size() == 0) begin
          $error("result transaction with no request waiting for it");
          errors++;
        end else begin
          wanted = results_due.pop_front();
          if (seen.status !== wanted.status) begin
            $error("status: expected %0d, got %0d", wanted.status, seen.status);
            errors++;
          end
          if (seen.out_sec !== wanted.out_sec) begin
            $error("out_sec: expected %0d, got %0d",
                   $signed(wanted.out_sec), $signed(seen.out_sec));
            errors++;
          end
          if (seen.out_nsec !== wanted.out_nsec) begin
            $error("out_nsec: expected %0d, got %0d", wanted.out_nsec, seen.out_nsec);
            errors++;
          end
          if (seen.old_sec !== wanted.old_sec) begin
            $error("old_sec: expected %0d, got %0d",
                   $signed(wanted.old_sec), $signed(seen.old_sec));
            errors++;
          end
          if (seen.old_usec !== wanted.old_usec) begin
            $error("old_usec: expected %0d, got %0d",
                   $signed(wanted.old_usec), $signed(seen.old_usec));
            errors++;
          end
        end
      end
    end
    mismatches <= errors;
    awaiting <= results_due.size();
  end

endmodule

// ===== bench/clock_slew_and_offset_test.sv =====
// stimulus, flow control and verdict for the clock slew and offset block
module clock_slew_and_offset_test;
  import cso_pkg::*;

  localparam int IN_PAD_W         = IN_TDATA_W - 164;
  localparam int SEGMENTS         = 6;
  localparam int ITEMS_PER_SEG    = 340;
  localparam int HOLD_CYCLES      = 200;
  localparam int SETTLE_CYCLES    = 4;
  localparam int CYCLE_LIMIT      = 400000;
  localparam logic [NSEC_W-1:0] STEP_ALL_ONES = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [NSEC_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int mismatches;
  int awaiting;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_wanted;
  bit hold_served;
  int unsigned cycles;

  logic [SEC_BITS-1:0] hw_now_sec;
  logic [NSEC_W-1:0]   hw_now_nsec;
  logic [NSEC_W-1:0]   step_plan[SEGMENTS];

  clock_slew_and_offset i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  clock_slew_and_offset_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run length guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic item_t clock_req(op_t op, logic [SEC_BITS-1:0] hs,
                                      logic [NSEC_W-1:0] hn, int as, int au,
                                      logic [SEC_BITS-1:0] ss, logic [19:0] su,
                                      sel_t sel);
    item_t it;
    it.op = op;
    it.hw_sec = hs;
    it.hw_nsec = hn;
    it.adj_sec = as[12:0];
    it.adj_usec = au[20:0];
    it.set_sec = ss;
    it.set_usec = su;
    it.clock_sel = sel;
    return it;
  endfunction

  // mostly small corrections on a forward-running raw clock, some noise
  function automatic item_t random_clock_request();
    item_t       it;
    logic [63:0] r64;
    logic [31:0] r32;
    int          v;
    int unsigned pick, n;
    n = {2'b0, hw_now_nsec} + $urandom_range(20000000);
    if (n >= NS_PER_SEC) begin
      n = n - NS_PER_SEC;
      hw_now_sec = hw_now_sec + 1'b1;
    end
    hw_now_nsec = n[NSEC_W-1:0];
    it.hw_sec = hw_now_sec;
    it.hw_nsec = hw_now_nsec;
    if ($urandom_range(19) == 0) begin
      r64 = {$urandom(), $urandom()};
      it.hw_sec = r64[SEC_BITS-1:0];
      it.hw_nsec = r64[63:34];
    end
    pick = $urandom_range(99);
    if (pick < 45) begin
      it.op = OP_TICK;
    end else if (pick < 65) begin
      it.op = OP_ADJUST;
    end else if (pick < 75) begin
      it.op = OP_SET;
    end else begin
      it.op = OP_READ;
    end
    // correction request
    pick = $urandom_range(99);
    if (pick < 10) begin
      it.adj_sec = '0;
      it.adj_usec = '0;
    end else if (pick < 55) begin
      it.adj_sec = '0;
      v = $urandom_range(128);
      v = v - 64;
      it.adj_usec = v[20:0];
    end else if (pick < 80) begin
      v = $urandom_range(4290);
      v = v - 2145;
      it.adj_sec = v[12:0];
      v = $urandom_range(2000000);
      v = v - 1000000;
      it.adj_usec = v[20:0];
    end else begin
      r64 = {$urandom(), $urandom()};
      it.adj_sec = r64[12:0];
      it.adj_usec = r64[53:33];
    end
    // set-time request
    r64 = {$urandom(), $urandom()};
    if ($urandom_range(1) == 0) begin
      it.set_sec = hw_now_sec + $urandom_range(1000);
    end else begin
      it.set_sec = r64[SEC_BITS-1:0];
    end
    r32 = $urandom();
    if ($urandom_range(9) == 0) begin
      it.set_usec = r32[19:0];
    end else begin
      v = $urandom_range(999999);
      it.set_usec = v[19:0];
    end
    it.clock_sel = sel_t'(r32[21:20]);
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{IN_PAD_W{1'b0}}, it.set_usec, it.set_sec, it.adj_usec, it.adj_sec,
                 it.hw_nsec, it.hw_sec};
    in_tuser <= {it.clock_sel, it.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic write_step(input logic [NSEC_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  localparam logic [SEC_BITS-1:0] SEC_TOP = '1;
  localparam logic [NSEC_W-1:0]   NS_TOP  = '1;

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    send_idle_pct = 14;
    recv_idle_pct = 74;
    hold_wanted = 1'b0;
    hw_now_sec = SEC_BITS'({$urandom(), $urandom()});
    hw_now_nsec = NSEC_W'($urandom_range(999999999));
    step_plan[0] = 30'd1;
    step_plan[1] = NSEC_MAX;
    step_plan[2] = '0;
    step_plan[3] = STEP_ALL_ONES;
    step_plan[4] = NSEC_W'($urandom_range(999999999, 1));
    step_plan[5] = STEP_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes and each corner of the corrector, reset step
    offer_item(clock_req(OP_READ, SEC_TOP, NS_TOP, 0, 0, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, 0, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, 1000001, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, -1000001, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 2146, 0, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, -4096, -1048576, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 4095, 1048575, 0, 0, SEL_RAW));
    // small speed-up drained by ticks, last tick clipped, then an idle tick
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, 12, 0, 0, SEL_RAW));
    repeat (4) offer_item(clock_req(OP_TICK, 0, 0, 0, 0, 0, 0, SEL_RAW));
    // slow-down, reported back as a negative correction
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, -7, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 0, 0, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_TICK, 0, 0, 0, 0, 0, 0, SEL_RAW));
    // correction summing to zero, then the largest each way
    offer_item(clock_req(OP_ADJUST, 0, 0, 1, -1000000, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, 2145, 1000000, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_ADJUST, 0, 0, -2145, -1000000, 0, 0, SEL_RAW));
    // borrow into the slew seconds, seen as a negative monotonic time
    repeat (2) offer_item(clock_req(OP_TICK, 0, 0, 0, 0, 0, 0, SEL_RAW));
    offer_item(clock_req(OP_READ, 0, 0, 0, 0, 0, 0, SEL_MONO));
    // set time: bad microseconds, then the largest valid time
    offer_item(clock_req(OP_SET, 0, 0, 0, 0, 0, 20'd1000000, SEL_RAW));
    offer_item(clock_req(OP_SET, 0, 0, 0, 0, SEC_TOP, 20'hFFFFF, SEL_RAW));
    offer_item(clock_req(OP_SET, 40'd12345, 30'd999999999, 0, 0, SEC_TOP, 20'd999999,
                         SEL_RAW));
    offer_item(clock_req(OP_READ, SEC_TOP, NS_TOP, 0, 0, 0, 0, SEL_REAL));
    offer_item(clock_req(OP_READ, 0, 0, 0, 0, 0, 0, SEL_REAL));
    offer_item(clock_req(OP_READ, 0, 0, 0, 0, 0, 0, SEL_BAD));

    // random segments, each with its own step and flow-control mix
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      write_step(step_plan[seg]);
      if (seg < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 74;
      end else if (seg < 4) begin
        send_idle_pct = 74;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 4) begin
        hold_wanted = 1'b1;
      end
      repeat (ITEMS_PER_SEG) offer_item(random_clock_request());
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
